FILE: rtl/triangle_tangent_bitangent_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the tangent / bitangent block
// clocked on aclk, disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BITANGENT_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_TOP_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("ttb assertion failed");

// next-cycle implication
`define TTB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("ttb assertion failed");

`endif

FILE: rtl/ttb_pkg.sv
// ---------------------------------------------------------------------------
// ttb_pkg
// shared types and constants of the tangent / bitangent block
// ---------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

    localparam int VERTEX_SLOTS = 256;
    localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
    localparam int COORD_W      = 16;
    localparam int DELTA_W      = 17;
    localparam int PROD_W       = 34;
    localparam int WIDE_W       = 35;
    localparam int OUT_W        = 32;
    localparam int VERT_W       = 5 * COORD_W;
    localparam int LANES        = 6;

    // request codes
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C
    } corner_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CAP_C,
        ST_MUL,
        ST_DIFF,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } ttb_state_t;

    typedef struct packed {
        logic        load_wr;
        logic        tri_latch;
        corner_sel_t rd_sel;
        logic        cap_a;
        logic        cap_b;
        logic        cap_c;
        logic        mul_en;
        logic        diff_en;
        logic        div_start;
        logic        out_load;
    } ttb_cmd_t;

    typedef struct packed {
        logic div_busy;
    } ttb_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ttb_div.sv
// ---------------------------------------------------------------------------
// ttb_div
// six-lane restoring divider: (num * 2^22) / det, toward zero, saturated
// ---------------------------------------------------------------------------
`default_nettype none

module ttb_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [ttb_pkg::WIDE_W-1:0]    num [ttb_pkg::LANES],
    input  wire logic signed [ttb_pkg::WIDE_W-1:0]    det,
    output logic                                      busy,
    output logic        [ttb_pkg::OUT_W-1:0]          quo [ttb_pkg::LANES]
);
    import ttb_pkg::*;

    localparam int FRAC   = 22;
    localparam int SHIFT  = 10;
    localparam int NUM_W  = WIDE_W + FRAC;
    localparam int REM_W  = WIDE_W + 1;
    localparam int CNT_W  = $clog2(OUT_W + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDE_W-1:0]    dmag_reg, dmag_next;
    logic [REM_W-1:0]     rem_reg  [LANES];
    logic [REM_W-1:0]     rem_next [LANES];
    logic [OUT_W-1:0]     nsh_reg  [LANES];
    logic [OUT_W-1:0]     nsh_next [LANES];
    logic [OUT_W-1:0]     q_reg    [LANES];
    logic [OUT_W-1:0]     q_next   [LANES];
    logic                 neg_reg  [LANES];
    logic                 neg_next [LANES];
    logic                 ovf_reg  [LANES];
    logic                 ovf_next [LANES];

    // divisor magnitude
    logic [WIDE_W-1:0] dmag_in;
    assign dmag_in = det[WIDE_W-1] ? WIDE_W'(-det) : WIDE_W'(det);

    // per-lane iteration
    always_comb begin
        logic [WIDE_W-1:0] mag;
        logic [NUM_W-1:0]  nfull;
        logic [REM_W-1:0]  trial;
        mag       = '0;
        nfull     = '0;
        trial     = '0;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dmag_next = dmag_reg;
        for (int i = 0; i < LANES; i++) begin
            rem_next[i] = rem_reg[i];
            nsh_next[i] = nsh_reg[i];
            q_next[i]   = q_reg[i];
            neg_next[i] = neg_reg[i];
            ovf_next[i] = ovf_reg[i];
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OUT_W);
            dmag_next = dmag_in;
            for (int i = 0; i < LANES; i++) begin
                mag         = num[i][WIDE_W-1] ? WIDE_W'(-num[i]) : WIDE_W'(num[i]);
                nfull       = {mag, {FRAC{1'b0}}};
                rem_next[i] = REM_W'(nfull[NUM_W-1:OUT_W]);
                nsh_next[i] = nfull[OUT_W-1:0];
                q_next[i]   = '0;
                neg_next[i] = num[i][WIDE_W-1] ^ det[WIDE_W-1];
                ovf_next[i] = {{SHIFT{1'b0}}, mag} >= {dmag_in, {SHIFT{1'b0}}};
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
            for (int i = 0; i < LANES; i++) begin
                trial       = {rem_reg[i][REM_W-2:0], nsh_reg[i][OUT_W-1]};
                nsh_next[i] = {nsh_reg[i][OUT_W-2:0], 1'b0};
                if (trial >= {1'b0, dmag_reg}) begin
                    rem_next[i] = trial - {1'b0, dmag_reg};
                    q_next[i]   = {q_reg[i][OUT_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = trial;
                    q_next[i]   = {q_reg[i][OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // lane registers
    always_ff @(posedge aclk) begin
        dmag_reg <= dmag_next;
        for (int i = 0; i < LANES; i++) begin
            rem_reg[i] <= rem_next[i];
            nsh_reg[i] <= nsh_next[i];
            q_reg[i]   <= q_next[i];
            neg_reg[i] <= neg_next[i];
            ovf_reg[i] <= ovf_next[i];
        end
    end

    // sign and saturation
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (neg_reg[i]) begin
                if (ovf_reg[i] || q_reg[i] > {1'b1, {(OUT_W-1){1'b0}}}) begin
                    quo[i] = {1'b1, {(OUT_W-1){1'b0}}};
                end else begin
                    quo[i] = -q_reg[i];
                end
            end else begin
                if (ovf_reg[i] || q_reg[i][OUT_W-1]) begin
                    quo[i] = {1'b0, {(OUT_W-1){1'b1}}};
                end else begin
                    quo[i] = q_reg[i];
                end
            end
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: rtl/ttb_ctrl.sv
// ---------------------------------------------------------------------------
// ttb_ctrl
// sequencer for vertex reads, products, division and result handoff
// ---------------------------------------------------------------------------
`default_nettype none

module ttb_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ttb_pkg::ttb_cmd_t       cmd,
    input  wire ttb_pkg::ttb_stat_t stat
);
    import ttb_pkg::*;

    ttb_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_req_type == REQ_TRIANGLE) state_next = ST_RD_A;
            end
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_RD_C;
            ST_RD_C:   state_next = ST_CAP_C;
            ST_CAP_C:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV: begin
                if (!stat.div_busy) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_wr   = s_valid && s_req_type == REQ_LOAD;
                cmd.tri_latch = s_valid && s_req_type == REQ_TRIANGLE;
            end
            ST_RD_A:   cmd.rd_sel = SEL_A;
            ST_RD_B: begin
                cmd.rd_sel = SEL_B;
                cmd.cap_a  = 1'b1;
            end
            ST_RD_C: begin
                cmd.rd_sel = SEL_C;
                cmd.cap_b  = 1'b1;
            end
            ST_CAP_C:  cmd.cap_c     = 1'b1;
            ST_MUL:    cmd.mul_en    = 1'b1;
            ST_DIFF:   cmd.diff_en   = 1'b1;
            ST_DIV_GO: cmd.div_start = 1'b1;
            ST_OUT:    cmd.out_load  = out_free;
            default:   cmd = '0;
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.out_load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/ttb_datapath.sv
// ---------------------------------------------------------------------------
// ttb_datapath
// vertex memory, edge and delta formation, products, divider and result regs
// ---------------------------------------------------------------------------
`default_nettype none

module ttb_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire ttb_pkg::ttb_cmd_t                     cmd,
    output ttb_pkg::ttb_stat_t                         stat,
    input  wire logic        [7:0]                     s_corner_a,
    input  wire logic        [7:0]                     s_corner_b,
    input  wire logic        [7:0]                     s_corner_c,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_x,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_y,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_z,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_tex_s,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_tex_t,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_z,
    output logic                                       m_degenerate
);
    import ttb_pkg::*;

    // vertex memory, one word per slot
    logic [VERT_W-1:0] vmem [VERTEX_SLOTS];
    logic [VERT_W-1:0] rdata_reg;
    logic [SLOT_W-1:0] a_reg, b_reg, c_reg;
    logic [SLOT_W-1:0] raddr;

    always_comb begin
        case (cmd.rd_sel)
            SEL_A:   raddr = a_reg;
            SEL_B:   raddr = b_reg;
            SEL_C:   raddr = c_reg;
            default: raddr = a_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            vmem[s_corner_a[SLOT_W-1:0]] <= {s_pos_x, s_pos_y, s_pos_z, s_tex_s, s_tex_t};
        end
        rdata_reg <= vmem[raddr];
    end

    // corner slots of a triangle
    always_ff @(posedge aclk) begin
        if (cmd.tri_latch) begin
            a_reg <= s_corner_a[SLOT_W-1:0];
            b_reg <= s_corner_b[SLOT_W-1:0];
            c_reg <= s_corner_c[SLOT_W-1:0];
        end
    end

    // unpacked read word
    logic signed [COORD_W-1:0] rd_pos [3];
    logic signed [COORD_W-1:0] rd_s, rd_t;
    assign rd_pos[0] = rdata_reg[5*COORD_W-1:4*COORD_W];
    assign rd_pos[1] = rdata_reg[4*COORD_W-1:3*COORD_W];
    assign rd_pos[2] = rdata_reg[3*COORD_W-1:2*COORD_W];
    assign rd_s      = rdata_reg[2*COORD_W-1:COORD_W];
    assign rd_t      = rdata_reg[COORD_W-1:0];

    // corner a, edges and uv deltas
    logic signed [COORD_W-1:0] pa_reg [3];
    logic signed [COORD_W-1:0] sa_reg, ta_reg;
    logic signed [DELTA_W-1:0] e0_reg [3];
    logic signed [DELTA_W-1:0] e1_reg [3];
    logic signed [DELTA_W-1:0] d0s_reg, d0t_reg, d1s_reg, d1t_reg;
    logic signed [DELTA_W-1:0] e_new [3];
    logic signed [DELTA_W-1:0] ds_new, dt_new;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_new[k] = DELTA_W'(rd_pos[k]) - DELTA_W'(pa_reg[k]);
        end
        ds_new = DELTA_W'(rd_s) - DELTA_W'(sa_reg);
        dt_new = DELTA_W'(rd_t) - DELTA_W'(ta_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            pa_reg <= rd_pos;
            sa_reg <= rd_s;
            ta_reg <= rd_t;
        end
        if (cmd.cap_b) begin
            e0_reg  <= e_new;
            d0s_reg <= ds_new;
            d0t_reg <= dt_new;
        end
        if (cmd.cap_c) begin
            e1_reg  <= e_new;
            d1s_reg <= ds_new;
            d1t_reg <= dt_new;
        end
    end

    // products, one register stage
    logic signed [PROD_W-1:0] pt0_reg [3];
    logic signed [PROD_W-1:0] pt1_reg [3];
    logic signed [PROD_W-1:0] pb0_reg [3];
    logic signed [PROD_W-1:0] pb1_reg [3];
    logic signed [PROD_W-1:0] pd0_reg, pd1_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            for (int k = 0; k < 3; k++) begin
                pt0_reg[k] <= d1t_reg * e0_reg[k];
                pt1_reg[k] <= d0t_reg * e1_reg[k];
                pb0_reg[k] <= d0s_reg * e1_reg[k];
                pb1_reg[k] <= d1s_reg * e0_reg[k];
            end
            pd0_reg <= d0s_reg * d1t_reg;
            pd1_reg <= d1s_reg * d0t_reg;
        end
    end

    // numerators and determinant
    logic signed [WIDE_W-1:0] num_reg [LANES];
    logic signed [WIDE_W-1:0] det_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff_en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k]     <= WIDE_W'(pt0_reg[k]) - WIDE_W'(pt1_reg[k]);
                num_reg[3 + k] <= WIDE_W'(pb0_reg[k]) - WIDE_W'(pb1_reg[k]);
            end
            det_reg <= WIDE_W'(pd0_reg) - WIDE_W'(pd1_reg);
        end
    end

    // division lanes
    logic [OUT_W-1:0] quo [LANES];
    logic             div_busy;

    ttb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .det     (det_reg),
        .busy    (div_busy),
        .quo     (quo)
    );

    assign stat.div_busy = div_busy;

    // result registers
    logic [OUT_W-1:0] res_reg [LANES];
    logic             deg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            deg_reg <= (det_reg == '0);
            for (int i = 0; i < LANES; i++) begin
                res_reg[i] <= (det_reg == '0) ? '0 : quo[i];
            end
        end
    end

    assign m_tangent_x   = res_reg[0];
    assign m_tangent_y   = res_reg[1];
    assign m_tangent_z   = res_reg[2];
    assign m_bitangent_x = res_reg[3];
    assign m_bitangent_y = res_reg[4];
    assign m_bitangent_z = res_reg[5];
    assign m_degenerate  = deg_reg;

endmodule

`default_nettype wire

FILE: rtl/triangle_tangent_bitangent_top.sv
// ---------------------------------------------------------------------------
// triangle_tangent_bitangent_top
// tangent and bitangent of a textured triangle from a 256-slot vertex store
// ---------------------------------------------------------------------------
// A load item (req_type 0) writes one vertex slot, producing no result. A
// triangle item (req_type 1) reads its three corners through the one read
// port of the vertex memory, one per cycle, forms edges and uv deltas, all
// products in one stage, the determinant and numerators, then runs six
// restoring divider lanes in parallel, one quotient bit per cycle. The block
// takes no new item while a triangle is in flight. Slots never loaded read
// back as undefined data.
`default_nettype none

module triangle_tangent_bitangent_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_req_type,
    input  wire logic        [7:0]                     s_corner_a,
    input  wire logic        [7:0]                     s_corner_b,
    input  wire logic        [7:0]                     s_corner_c,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_x,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_y,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_pos_z,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_tex_s,
    input  wire logic signed [ttb_pkg::COORD_W-1:0]    s_tex_t,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]           m_bitangent_z,
    output logic                                       m_degenerate
);
    import ttb_pkg::*;

    ttb_cmd_t  cmd;
    ttb_stat_t stat;

    // sequencer
    ttb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // arithmetic and storage
    ttb_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_corner_a    (s_corner_a),
        .s_corner_b    (s_corner_b),
        .s_corner_c    (s_corner_c),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_tex_s       (s_tex_s),
        .s_tex_t       (s_tex_t),
        .m_tangent_x   (m_tangent_x),
        .m_tangent_y   (m_tangent_y),
        .m_tangent_z   (m_tangent_z),
        .m_bitangent_x (m_bitangent_x),
        .m_bitangent_y (m_bitangent_y),
        .m_bitangent_z (m_bitangent_z),
        .m_degenerate  (m_degenerate)
    );

    // checks
    `include "triangle_tangent_bitangent_top_assert.svh"

    `TTB_ASSERT_NEXT(a_tri_blocks, s_valid && s_ready && s_req_type == REQ_TRIANGLE, !s_ready)
    `TTB_ASSERT_NEXT(a_div_runs, cmd.div_start, stat.div_busy)
    `TTB_ASSERT_IMPL(a_degen_zero, m_valid && m_degenerate, m_tangent_x == 0 && m_tangent_y == 0 && m_tangent_z == 0 && m_bitangent_x == 0 && m_bitangent_y == 0 && m_bitangent_z == 0)

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench for triangle_tangent_bitangent_top
// loads vertex slots and requests triangles with random bursts, stalls and
// long back-pressure; an internal predictor computes expected vectors on
// each accepted triangle, and the monitor checks them field by field in order
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ttb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 500;

    typedef struct {
        logic                     req_type;
        logic [7:0]               corner_a;
        logic [7:0]               corner_b;
        logic [7:0]               corner_c;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_s;
        logic signed [COORD_W-1:0] tex_t;
        bit                       drain_first;
    } vertex_req_t;

    typedef struct {
        logic signed [OUT_W-1:0] tan_x, tan_y, tan_z;
        logic signed [OUT_W-1:0] bit_x, bit_y, bit_z;
        logic                    degen;
    } frame_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_LOAD;
    logic [7:0] s_corner_a = '0, s_corner_b = '0, s_corner_c = '0;
    logic signed [COORD_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [COORD_W-1:0] s_tex_s = '0, s_tex_t = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic signed [OUT_W-1:0] m_bitangent_x, m_bitangent_y, m_bitangent_z;
    logic m_degenerate;

    vertex_req_t pending_items[$];
    frame_t      expected_frames[$];

    // predictor copy of the vertex store
    logic signed [COORD_W-1:0] pos_mem[VERTEX_SLOTS][3];
    logic signed [COORD_W-1:0] tex_mem[VERTEX_SLOTS][2];

    // generator side bookkeeping of loaded slots
    bit   slot_loaded[VERTEX_SLOTS];
    int   loaded_list[$];

    int error_count = 0;
    int cycle_count = 0;
    int accepted_count = 0;
    int load_count = 0, triangle_count = 0;
    int frame_count = 0, degen_count = 0, sat_count = 0;
    bit hold_done = 0;

    triangle_tangent_bitangent_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_corner_a(s_corner_a), .s_corner_b(s_corner_b), .s_corner_c(s_corner_c),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_tex_s(s_tex_s), .s_tex_t(s_tex_t),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tangent_x(m_tangent_x), .m_tangent_y(m_tangent_y),
        .m_tangent_z(m_tangent_z), .m_bitangent_x(m_bitangent_x),
        .m_bitangent_y(m_bitangent_y), .m_bitangent_z(m_bitangent_z),
        .m_degenerate(m_degenerate)
    );

    always #5 aclk = ~aclk;

    // Q10.22 quotient, truncated toward zero and clamped
    function automatic logic signed [OUT_W-1:0] q16_quotient(longint num, longint det);
        longint q;
        q = (num * 64'sd4194304) / det;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[OUT_W-1:0];
    endfunction

    // tangent frame of the triangle a, b, c from the current store
    function automatic frame_t tangent_frame(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        frame_t f;
        longint e0[3], e1[3];
        longint d0s, d0t, d1s, d1t, det;
        logic signed [OUT_W-1:0] tv[3], bv[3];
        for (int k = 0; k < 3; k++) begin
            e0[k] = longint'(pos_mem[b][k]) - longint'(pos_mem[a][k]);
            e1[k] = longint'(pos_mem[c][k]) - longint'(pos_mem[a][k]);
        end
        d0s = longint'(tex_mem[b][0]) - longint'(tex_mem[a][0]);
        d0t = longint'(tex_mem[b][1]) - longint'(tex_mem[a][1]);
        d1s = longint'(tex_mem[c][0]) - longint'(tex_mem[a][0]);
        d1t = longint'(tex_mem[c][1]) - longint'(tex_mem[a][1]);
        det = d0s * d1t - d1s * d0t;
        for (int k = 0; k < 3; k++) begin
            if (det == 0) begin
                tv[k] = '0;
                bv[k] = '0;
            end else begin
                tv[k] = q16_quotient(d1t * e0[k] - d0t * e1[k], det);
                bv[k] = q16_quotient(d0s * e1[k] - d1s * e0[k], det);
            end
        end
        f.tan_x = tv[0]; f.tan_y = tv[1]; f.tan_z = tv[2];
        f.bit_x = bv[0]; f.bit_y = bv[1]; f.bit_z = bv[2];
        f.degen = (det == 0);
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %h, expected %h (result %0d)", what, got, want, frame_count);
        error_count++;
    endtask

    // stimulus builders
    task automatic add_load(int slot, int px, int py, int pz, int ts, int tt);
        vertex_req_t r;
        r.req_type = REQ_LOAD;
        r.corner_a = slot[7:0];
        r.corner_b = 8'($urandom); r.corner_c = 8'($urandom);
        r.pos_x = px[COORD_W-1:0]; r.pos_y = py[COORD_W-1:0]; r.pos_z = pz[COORD_W-1:0];
        r.tex_s = ts[COORD_W-1:0]; r.tex_t = tt[COORD_W-1:0];
        r.drain_first = 0;
        pending_items = {pending_items, r};
        if (!slot_loaded[slot[7:0]]) loaded_list = {loaded_list, slot};
        slot_loaded[slot[7:0]] = 1;
    endtask

    task automatic add_triangle(int a, int b, int c, bit drain);
        vertex_req_t r;
        r.req_type = REQ_TRIANGLE;
        r.corner_a = a[7:0]; r.corner_b = b[7:0]; r.corner_c = c[7:0];
        r.pos_x = COORD_W'($urandom); r.pos_y = COORD_W'($urandom);
        r.pos_z = COORD_W'($urandom);
        r.tex_s = COORD_W'($urandom); r.tex_t = COORD_W'($urandom);
        r.drain_first = drain;
        pending_items = {pending_items, r};
    endtask

    // mostly modest coordinates so quotients stay in range, sometimes full range
    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 255)) - 128;
            default: return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    // driver: bursts with gaps, predicts on each accepted item
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge aclk) begin
        vertex_req_t nx;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accepted_count++;
                if (s_req_type == REQ_LOAD) begin
                    pos_mem[s_corner_a][0] = s_pos_x;
                    pos_mem[s_corner_a][1] = s_pos_y;
                    pos_mem[s_corner_a][2] = s_pos_z;
                    tex_mem[s_corner_a][0] = s_tex_s;
                    tex_mem[s_corner_a][1] = s_tex_t;
                    load_count++;
                end else begin
                    expected_frames = {expected_frames,
                                       tangent_frame(s_corner_a, s_corner_b, s_corner_c)};
                    triangle_count++;
                end
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() == 0 ||
                             (pending_items[0].drain_first && expected_frames.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    nx = pending_items.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= nx.req_type;
                    s_corner_a <= nx.corner_a;
                    s_corner_b <= nx.corner_b;
                    s_corner_c <= nx.corner_c;
                    s_pos_x <= nx.pos_x; s_pos_y <= nx.pos_y; s_pos_z <= nx.pos_z;
                    s_tex_s <= nx.tex_s; s_tex_t <= nx.tex_t;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // receiver stall pattern and one long hold-off
    int stall_mode = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cycle_count % 150 == 0) stall_mode = $urandom_range(0, 2);
            if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        frame_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $display("unexpected result item (result %0d)", frame_count);
                error_count++;
            end else begin
                w = expected_frames.pop_front();
                if (m_tangent_x !== w.tan_x) report_mismatch("tangent_x", m_tangent_x, w.tan_x);
                if (m_tangent_y !== w.tan_y) report_mismatch("tangent_y", m_tangent_y, w.tan_y);
                if (m_tangent_z !== w.tan_z) report_mismatch("tangent_z", m_tangent_z, w.tan_z);
                if (m_bitangent_x !== w.bit_x) report_mismatch("bitangent_x", m_bitangent_x, w.bit_x);
                if (m_bitangent_y !== w.bit_y) report_mismatch("bitangent_y", m_bitangent_y, w.bit_y);
                if (m_bitangent_z !== w.bit_z) report_mismatch("bitangent_z", m_bitangent_z, w.bit_z);
                if (m_degenerate !== w.degen)
                    report_mismatch("degenerate", OUT_W'(m_degenerate), OUT_W'(w.degen));
                if (w.degen) degen_count++;
                if (w.tan_x == 32'sh7fffffff || w.tan_x == -32'sh80000000) sat_count++;
            end
            frame_count++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triangle_tangent_bitangent_top regression: fail");
            $finish;
        end
    end

    initial begin
        int a, b, c, n;
        // directed: extremes, unit frame, degenerate and saturating triangles
        add_load(0, -32768, -32768, -32768, -32768, -32768);
        add_load(255, 32767, 32767, 32767, 32767, 32767);
        add_load(1, 0, 0, 0, 0, 0);
        add_load(128, 32767, -32768, 0, -32768, 32767);
        add_load(2, 0, 0, 0, 0, 0);
        add_load(3, 256, 0, 0, 16384, 0);
        add_load(4, 0, 256, 0, 0, 16384);
        add_load(5, 32767, -32768, 32767, 1, 0);
        add_load(6, -32768, 32767, -32768, 0, 1);
        add_load(7, 100, 200, 300, 2, 2);
        add_triangle(2, 3, 4, 0);
        add_triangle(0, 255, 1, 0);
        add_triangle(255, 0, 128, 0);
        add_triangle(1, 128, 255, 0);
        add_triangle(0, 0, 1, 0);
        add_triangle(2, 2, 2, 0);
        add_triangle(1, 5, 6, 0);
        add_triangle(1, 6, 5, 0);
        add_triangle(1, 5, 7, 0);
        add_triangle(3, 4, 2, 1);
        add_load(3, -256, 0, 0, -16384, 0);
        add_triangle(2, 3, 4, 0);

        // random: mostly triangles on loaded slots, reloads with random content
        for (int i = 0; i < 1230; i++) begin
            n = $urandom_range(0, 99);
            if (n < 30) begin
                a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 255);
                add_load(a, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord());
            end else begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                if (n < 35) b = a;
                add_triangle(a, b, c, (i % 200) == 199);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("covered %0d loads and %0d triangles, %0d results checked",
                 load_count, triangle_count, frame_count);
        $display("%0d degenerate results, %0d with saturated tangent x, %0d mismatches",
                 degen_count, sat_count, error_count);
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("triangle_tangent_bitangent_top regression: pass");
        end else begin
            $display("triangle_tangent_bitangent_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_div.sv
rtl/ttb_ctrl.sv
rtl/ttb_datapath.sv
rtl/triangle_tangent_bitangent_top.sv
test/testbench.sv
